@@ hdl/bmhq_pkg.sv @@
// Shared types, widths and codes for the binary min-heap priority queue.
// No dependencies; every other file of the block imports this package.
package bmhq_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned CAP_W           = 7;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned OCC_OUT_W       = 7;

  localparam logic [CAP_W-1:0] CAP_RESET   = 7'd64;
  localparam logic [KEY_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;
  localparam logic [KEY_W-1:0] ZERO_VALUE  = 32'h0000_0000;

  // Operation codes carried on in_func
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins_en;
    logic ext_en;
  } bmhq_ctl_t;

  function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    key_less = $signed(a) < $signed(b);
  endfunction

endpackage

@@ hdl/bmhq_cell.sv @@
// One storage cell of the sorted key row; holds a single key.
// Depends on bmhq_pkg for widths, the command struct and key_less.
module bmhq_cell (
  input  logic                        clk,
  input  bmhq_pkg::bmhq_ctl_t         ctl,
  input  logic [bmhq_pkg::KEY_W-1:0]  key,
  input  logic                        valid,
  input  logic                        ins_prev,
  input  logic [bmhq_pkg::KEY_W-1:0]  data_prev,
  input  logic [bmhq_pkg::KEY_W-1:0]  data_next,
  output logic                        ins,
  output logic [bmhq_pkg::KEY_W-1:0]  data
);
  import bmhq_pkg::*;

  logic [KEY_W-1:0] data_r;
  logic [KEY_W-1:0] data_nxt;

  // New key belongs at or before this cell; an empty cell always qualifies
  assign ins  = !valid || key_less(key, data_r);
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_en) begin
      if (ins_prev) begin
        data_nxt = data_prev;   // shift right to make room
      end else if (ins) begin
        data_nxt = key;         // insertion point
      end
    end else if (ctl.ext_en) begin
      data_nxt = data_next;     // advance toward the head
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ hdl/binary_min_heap_queue_unit.sv @@
// Min priority queue of signed 32-bit keys, kept as a row of MAX_ENTRIES sorted cells.
// Depends on bmhq_pkg and bmhq_cell.
//
// For each item (insert or extract-min), every cell compares the incoming key with its
// own in the same cycle and shifts toward its neighbor, so the row keeps ascending order
// and the minimum always sits in the first cell. The result appears in the output
// register on the cycle after the beat is accepted, and a new item is taken every cycle
// as long as the result side does not stall. The key row has no reset and needs no
// clearing; occupancy alone marks which cells hold keys.
module binary_min_heap_queue_unit #(
  parameter int unsigned MAX_ENTRIES = bmhq_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [bmhq_pkg::KEY_W-1:0]        in_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmhq_pkg::KEY_W-1:0]        out_value,
  output logic [bmhq_pkg::STATUS_W-1:0]     out_status,
  output logic [bmhq_pkg::OCC_OUT_W-1:0]    out_occupancy_out,
  input  logic                              cfg_wr_en,
  input  logic [bmhq_pkg::CAP_W-1:0]        cfg_wr_data
);
  import bmhq_pkg::*;

  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [CAP_W-1:0]    cap_r;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    value_r, value_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OCC_OUT_W-1:0] occ_out_r;

  logic                accept;
  logic                full;
  logic                empty;
  logic [CMP_W-1:0]    cap_ext, max_ext, occ_ext, eff_cap;
  bmhq_ctl_t           ctl;

  logic [KEY_W-1:0]       cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_ins;
  logic [MAX_ENTRIES-1:0] cell_valid;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign cap_ext = CMP_W'(cap_r);
  assign max_ext = CMP_W'(MAX_ENTRIES);
  assign occ_ext = CMP_W'(occ_r);
  assign eff_cap = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign full    = occ_ext >= eff_cap;
  assign empty   = (occ_r == '0);

  always_comb begin
    ctl        = '0;
    occ_nxt    = occ_r;
    value_nxt  = ZERO_VALUE;
    status_nxt = ST_OK;
    if (in_func == FUNC_INSERT) begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        ctl.ins_en = accept;
        occ_nxt    = occ_r + OCC_W'(1);
      end
    end else begin
      if (empty) begin
        value_nxt  = EMPTY_VALUE;
        status_nxt = ST_EMPTY;
      end else begin
        ctl.ext_en = accept;
        value_nxt  = cell_data[0];
        occ_nxt    = occ_r - OCC_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;   // beat taken, drop valid
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (accept) begin
        occ_r <= occ_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r   <= value_nxt;
      status_r  <= status_nxt;
      occ_out_r <= OCC_OUT_W'(occ_nxt);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic             ins_prev;
      logic [KEY_W-1:0] data_prev;
      logic [KEY_W-1:0] data_next;

      assign cell_valid[gi] = (occ_r > OCC_W'(gi));

      if (gi == 0) begin : g_head
        assign ins_prev  = 1'b0;
        assign data_prev = cell_data[gi];
      end else begin : g_body
        assign ins_prev  = cell_ins[gi-1];
        assign data_prev = cell_data[gi-1];
      end

      if (gi == MAX_ENTRIES - 1) begin : g_tail
        assign data_next = cell_data[gi];
      end else begin : g_mid
        assign data_next = cell_data[gi+1];
      end

      bmhq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .key       (in_key),
        .valid     (cell_valid[gi]),
        .ins_prev  (ins_prev),
        .data_prev (data_prev),
        .data_next (data_next),
        .ins       (cell_ins[gi]),
        .data      (cell_data[gi])
      );
    end
  endgenerate

  assign out_valid         = out_valid_r;
  assign out_value         = value_r;
  assign out_status        = status_r;
  assign out_occupancy_out = occ_out_r;

endmodule

@@ hdl/bmhq_checker.sv @@
// Port-level checks for binary_min_heap_queue_unit, attached by bind.
// Depends on bmhq_pkg for widths and status codes.
module bmhq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_func,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bmhq_pkg::KEY_W-1:0]        out_value,
  input logic [bmhq_pkg::STATUS_W-1:0]     out_status,
  input logic [bmhq_pkg::OCC_OUT_W-1:0]    out_occupancy_out
);
  import bmhq_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status)
      && $stable(out_occupancy_out))
    else $error("stalled result beat changed");

  // Every accepted item shows its result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_value == EMPTY_VALUE
      && out_occupancy_out == '0)
    else $error("empty extract with wrong value or occupancy");

  a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> out_value == ZERO_VALUE)
    else $error("overflow result with wrong value");

  a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_INSERT |=> out_status != ST_EMPTY)
    else $error("insert reported empty");

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (.*);

@@ sim/bmhq_result_checker.sv @@
// Result checker for binary_min_heap_queue_unit: tracks its own heap and capacity,
// predicts one result per accepted input beat and compares every result beat.
// Depends on bmhq_pkg; instantiated by binary_min_heap_queue_unit_test.
module bmhq_result_checker #(
  parameter int unsigned MAX_ENTRIES = bmhq_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_func,
  input  logic [bmhq_pkg::KEY_W-1:0]          in_key,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [bmhq_pkg::KEY_W-1:0]          out_value,
  input  logic [bmhq_pkg::STATUS_W-1:0]       out_status,
  input  logic [bmhq_pkg::OCC_OUT_W-1:0]      out_occupancy_out,
  input  logic                                cfg_wr_en,
  input  logic [bmhq_pkg::CAP_W-1:0]          cfg_wr_data,
  output int unsigned                         fail_count,
  output int unsigned                         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmhq_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]     value;
    logic [STATUS_W-1:0]  status;
    logic [OCC_OUT_W-1:0] occupancy;
  } result_beat_t;

  logic [KEY_W-1:0] heap_keys [MAX_ENTRIES];
  int unsigned      heap_count;
  logic [CAP_W-1:0] cap_reg;
  result_beat_t     predicted_results [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count = fail_count + 1;
  endtask

  // Apply one operation to the tracked heap and return the result it produces.
  function automatic result_beat_t heap_apply(input logic op, input logic [KEY_W-1:0] key);
    result_beat_t     beat;
    int unsigned      limit;
    int unsigned      pos;
    int unsigned      next;
    int unsigned      lc;
    int unsigned      rc;
    logic [KEY_W-1:0] tmp;
    logic             settled;
    beat.value = ZERO_VALUE;
    beat.status = ST_OK;
    limit = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
    if (op == FUNC_INSERT) begin
      if (heap_count >= limit) begin
        beat.status = ST_OVERFLOW;
      end else begin
        pos = heap_count;
        heap_keys[pos] = key;
        heap_count++;
        settled = 1'b0;
        // sift up while the parent is strictly greater
        while (pos != 0 && !settled) begin
          next = (pos - 1) / 2;
          if ($signed(heap_keys[pos]) < $signed(heap_keys[next])) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[next];
            heap_keys[next] = tmp;
            pos = next;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else if (heap_count == 0) begin
      beat.value = EMPTY_VALUE;
      beat.status = ST_EMPTY;
    end else begin
      beat.value = heap_keys[0];
      heap_count--;
      heap_keys[0] = heap_keys[heap_count];
      pos = 0;
      settled = 1'b0;
      // sift down toward the smaller child, left child on a tie
      while (!settled) begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        if (lc >= heap_count) begin
          settled = 1'b1;
        end else begin
          next = lc;
          if (rc < heap_count && $signed(heap_keys[rc]) < $signed(heap_keys[lc])) begin
            next = rc;
          end
          if ($signed(heap_keys[next]) < $signed(heap_keys[pos])) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[next];
            heap_keys[next] = tmp;
            pos = next;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end
    beat.occupancy = OCC_OUT_W'(heap_count);
    return beat;
  endfunction

  always @(posedge clk) begin
    result_beat_t exp_beat;
    if (!rst_n) begin
      heap_count = 0;
      cap_reg = CAP_RESET;
      predicted_results.delete();
    end else begin
      if (cfg_wr_en) begin
        cap_reg = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        predicted_results.push_back(heap_apply(in_func, in_key));
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (value %0d)",
                                    $signed(out_value)));
        end else begin
          exp_beat = predicted_results.pop_front();
          if (out_value !== exp_beat.value) begin
            report_mismatch($sformatf("value %0d, expected %0d",
                                      $signed(out_value), $signed(exp_beat.value)));
          end
          if (out_status !== exp_beat.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_beat.status));
          end
          if (out_occupancy_out !== exp_beat.occupancy) begin
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      out_occupancy_out, exp_beat.occupancy));
          end
        end
      end
    end
    pending_results <= predicted_results.size();
  end

endmodule

@@ sim/binary_min_heap_queue_unit_test.sv @@
// Top of the testbench for binary_min_heap_queue_unit: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on bmhq_pkg and bmhq_result_checker.
module binary_min_heap_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmhq_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES      = 15;
  localparam int unsigned PHASE_OPS   = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = FUNC_INSERT;
  logic [KEY_W-1:0]     in_key = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KEY_W-1:0]     out_value;
  logic [STATUS_W-1:0]  out_status;
  logic [OCC_OUT_W-1:0] out_occupancy_out;
  logic                 cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]     cfg_wr_data = '0;

  int unsigned fail_count;
  int unsigned pending_results;
  logic        idle_on = 1'b1;
  logic        pressure_req = 1'b0;

  binary_min_heap_queue_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_occupancy_out (out_occupancy_out),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  bmhq_result_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_occupancy_out (out_occupancy_out),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .pending_results   (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one beat, with an optional idle gap first; return at the accepting edge.
  task automatic send_op(input logic op, input logic [KEY_W-1:0] key);
    if (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain all outstanding results, then write the capacity register.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    logic        pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (pressure_req && !pressure_done) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 25);
      end
      @(posedge clk);
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned      phase_caps [PHASES];
    int unsigned      insert_pct [PHASES];
    logic [KEY_W-1:0] key;
    logic             op;
    phase_caps = '{64, 64, 127, 8, 64, 0, 64, 1, 64, 2, 100, 64, 33, 64, 16};
    insert_pct = '{90, 60, 50, 40, 85, 30, 55, 60, 95, 50, 40, 70, 60, 20, 50};
    phase_caps[12] = $urandom_range(1, 64);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty extract, extremes and equal keys, then drain in order
    send_op(FUNC_EXTRACT, $urandom());
    send_op(FUNC_INSERT, 32'h7FFF_FFFF);
    send_op(FUNC_INSERT, 32'h8000_0000);
    send_op(FUNC_INSERT, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'hFFFF_FFFF);
    send_op(FUNC_INSERT, 32'd5);
    send_op(FUNC_INSERT, 32'd5);
    send_op(FUNC_INSERT, 32'd1);
    repeat (8) send_op(FUNC_EXTRACT, $urandom());

    // single-entry capacity: second insert overflows
    set_capacity(7'd1);
    send_op(FUNC_INSERT, 32'd10);
    send_op(FUNC_INSERT, 32'd20);
    send_op(FUNC_EXTRACT, $urandom());

    // zero capacity: every insert overflows
    set_capacity(7'd0);
    send_op(FUNC_INSERT, $urandom());

    // capacity lowered below the current occupancy
    set_capacity(7'd64);
    repeat (3) send_op(FUNC_INSERT, $urandom());
    set_capacity(7'd2);
    send_op(FUNC_INSERT, $urandom());

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(CAP_W'(phase_caps[p]));
      idle_on = (p != 2);
      if (p == 1) begin
        pressure_req = 1'b1;
      end
      for (int n = 0; n < PHASE_OPS; n++) begin
        op = ($urandom_range(99) < insert_pct[p]) ? FUNC_INSERT : FUNC_EXTRACT;
        case ($urandom_range(9))
          0: key = 32'h8000_0000 + $urandom_range(3);
          1: key = 32'h7FFF_FFFF - $urandom_range(3);
          2, 3: key = $urandom_range(8) - 4;  // crowd in duplicates
          default: key = $urandom();
        endcase
        send_op(op, key);
      end
    end

    in_valid <= 1'b0;
    idle_on = 1'b1;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
